[rtl/rolling_remote_code_scrambler_defines.svh]
// Assertion macros shared by the checker of the rolling remote code scrambler.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ROLLING_REMOTE_CODE_SCRAMBLER_DEFINES_SVH
`define ROLLING_REMOTE_CODE_SCRAMBLER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RRCS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("rrcs: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RRCS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("rrcs: next-cycle check failed");

`endif

[rtl/rrcs_pkg.sv]
// Constants, scramble table and lookup functions of the rolling remote code scrambler.
// Depends on nothing; used by rrcs_scramble and the top level.
package rrcs_pkg;

   localparam int DEVICE_CODE_W = 16;
   localparam int COMMAND_W     = 8;
   localparam int FRAME_CODE_W  = 28;
   localparam int ROLL_COUNT_W  = 2;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 32;

   localparam int NIBBLES      = 7;
   localparam int PASS_NIBBLES = 6;

   localparam logic [3:0] LEAD_NIBBLE = 4'h1;
   localparam logic [3:0] LAST_MASK   = 4'h9;

   localparam logic [11:0] SCR_TABLE [16] = '{
      12'h609, 12'h306, 12'h803, 12'ha08,
      12'h00a, 12'h200, 12'hc02, 12'h40c,
      12'he04, 12'h70e, 12'h507, 12'h105,
      12'hf01, 12'hb0f, 12'hd0b, 12'h90d
   };

   function automatic logic [3:0] scr_hi(input logic [3:0] idx);
      logic [11:0] entry;
      entry = SCR_TABLE[idx];
      return entry[11:8];
   endfunction

   function automatic logic [3:0] scr_lo(input logic [3:0] idx);
      logic [11:0] entry;
      entry = SCR_TABLE[idx];
      return entry[3:0];
   endfunction

endpackage

[rtl/rrcs_scramble.sv]
// Combinational frame builder: plain nibbles, two chained table passes, packing and rotation.
// Depends on rrcs_pkg.
module rrcs_scramble (
   input  logic [rrcs_pkg::DEVICE_CODE_W-1:0] device_code,
   input  logic [rrcs_pkg::COMMAND_W-1:0]     command,
   input  logic [rrcs_pkg::ROLL_COUNT_W-1:0]  roll_count,
   output logic [rrcs_pkg::FRAME_CODE_W-1:0]  frame_code
);

   logic [3:0] plain  [rrcs_pkg::NIBBLES];
   logic [3:0] first  [rrcs_pkg::PASS_NIBBLES];
   logic [3:0] second [rrcs_pkg::NIBBLES];
   logic [rrcs_pkg::FRAME_CODE_W-1:0] packed_code;
   logic [2:0] level;

   always_comb begin
      level    = 3'(command - 8'd1);
      plain[0] = rrcs_pkg::LEAD_NIBBLE;
      plain[1] = {roll_count, (command != '0), 1'b0};
      plain[2] = device_code[3:0];
      plain[3] = device_code[7:4];
      plain[4] = device_code[11:8];
      plain[5] = device_code[15:12];
      if (command inside {[8'd1:8'd8]}) begin
         plain[6] = {1'b1, level};
      end else begin
         plain[6] = 4'h0;
      end

      first[0] = rrcs_pkg::scr_hi(plain[0]);
      for (int k = 1; k < rrcs_pkg::PASS_NIBBLES; k++) begin
         first[k] = rrcs_pkg::scr_hi(plain[k] ^ first[k-1]);
      end

      second[0] = rrcs_pkg::scr_lo(first[0]);
      for (int k = 1; k < rrcs_pkg::PASS_NIBBLES; k++) begin
         second[k] = rrcs_pkg::scr_lo(first[k] ^ second[k-1]);
      end
      second[6] = plain[6] ^ rrcs_pkg::LAST_MASK;

      for (int k = 0; k < rrcs_pkg::NIBBLES; k++) begin
         packed_code[4*k +: 4] = second[k];
      end
      frame_code = {packed_code[1:0], packed_code[rrcs_pkg::FRAME_CODE_W-1:2]};
   end

endmodule

[rtl/rolling_remote_code_scrambler.sv]
// Top level of the rolling remote code scrambler: input register, rolling counter,
// frame builder and result register. Depends on rrcs_pkg and rrcs_scramble.
//
//   channel  direction  tdata fields (lowest bit first)
//   req_     in         device_code[15:0], command[23:16]
//   rsp_     out        frame_code[27:0], rolling_count[29:28], zero[31:30]
//
// Each item passes an input register and then a result register. One item is
// accepted every cycle while the result side takes items. The rolling counter
// steps on each accepted item.
// Reset clears the counter and both registers' valid flags. A stalled result holds
// its register and the input register still takes one more item behind it.
module rolling_remote_code_scrambler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rrcs_pkg::REQ_DATA_W-1:0] req_tdata,  // device_code, command
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rrcs_pkg::RSP_DATA_W-1:0] rsp_tdata   // frame_code, rolling_count, zeros
);

   logic [rrcs_pkg::ROLL_COUNT_W-1:0]  count_ff, count_in;
   logic                               s1_valid_ff, s1_valid_in;
   logic [rrcs_pkg::DEVICE_CODE_W-1:0] s1_code_ff;
   logic [rrcs_pkg::COMMAND_W-1:0]     s1_cmd_ff;
   logic [rrcs_pkg::ROLL_COUNT_W-1:0]  s1_count_ff;
   logic                               s2_valid_ff, s2_valid_in;
   logic [rrcs_pkg::FRAME_CODE_W-1:0]  s2_frame_ff;
   logic [rrcs_pkg::ROLL_COUNT_W-1:0]  s2_count_ff;
   logic [rrcs_pkg::FRAME_CODE_W-1:0]  frame_code;
   logic                               req_accept, s2_ready, s1_move;

   assign s2_ready   = !s2_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && s2_ready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_accept = req_tvalid && req_tready;

   assign count_in    = count_ff + 2'd1;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s2_ready);
   assign s2_valid_in = s1_move || (s2_valid_ff && !rsp_tready);

   rrcs_scramble u_scramble (
      .device_code (s1_code_ff),
      .command     (s1_cmd_ff),
      .roll_count  (s1_count_ff),
      .frame_code  (frame_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (req_accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_code_ff  <= req_tdata[15:0];
         s1_cmd_ff   <= req_tdata[23:16];
         s1_count_ff <= count_in;
      end
      if (s1_move) begin
         s2_frame_ff <= frame_code;
         s2_count_ff <= s1_count_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {2'b00, s2_count_ff, s2_frame_ff};

endmodule

[rtl/rrcs_checker.sv]
// Port-level checker of the rolling remote code scrambler, bound to the top level.
// Depends on rolling_remote_code_scrambler_defines.svh and rrcs_pkg.
`include "rolling_remote_code_scrambler_defines.svh"

module rrcs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rrcs_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [rrcs_pkg::ROLL_COUNT_W-1:0] last_count_ff;
   logic [rrcs_pkg::ROLL_COUNT_W-1:0] rsp_count;
   logic [rrcs_pkg::ROLL_COUNT_W-1:0] next_count;
   logic                              rsp_accept;
   logic                              rsp_stall;

   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_count  = rsp_tdata[29:28];
   assign next_count = last_count_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
      end else if (rsp_accept) begin
         last_count_ff <= rsp_count;
      end
   end

   // Every delivered item carries the next value of the rolling counter.
   `RRCS_ASSERT_IMPLY(a_count_steps, clock, reset, rsp_accept, rsp_count == next_count)
   // The pad bits above the rolling count stay zero.
   `RRCS_ASSERT_IMPLY(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[31:30] == 2'b00)
   // With no result waiting, the input side is always open.
   `RRCS_ASSERT_IMPLY(a_open_when_empty, clock, reset, !rsp_tvalid, req_tready)
   // A stalled result keeps its value.
   `RRCS_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // Reset empties the result register.
   `RRCS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind rolling_remote_code_scrambler rrcs_checker u_rrcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
